@@ rtl/signed_decimal_to_ascii_core_assert.svh @@
// Assertion macros for the signed decimal to ASCII core.
// Used by rtl/signed_decimal_to_ascii_core.sv; expects clk and rst_n in scope.
`ifndef SIGNED_DECIMAL_TO_ASCII_CORE_ASSERT_SVH
`define SIGNED_DECIMAL_TO_ASCII_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define SD2A_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked outside reset
`define SD2A_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SD2A_ASSERT_NOW(label, ante, cons)
`define SD2A_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/sd2a_pkg.sv @@
// Shared constants and helpers for the signed decimal to ASCII core.
// No dependencies; used by sd2a_div10 and signed_decimal_to_ascii_core.
`default_nettype none

package sd2a_pkg;

  localparam int unsigned MagW   = 32;
  localparam int unsigned QuotW  = 29;  // floor((2^32-1)/10) fits in 29 bits
  localparam int unsigned CodeW  = 7;
  localparam int unsigned ColW   = 4;
  localparam int unsigned DigitW = 4;

  localparam logic [CodeW-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CodeW-1:0] ASCII_MINUS = 7'h2D;

  // Reciprocal of ten scaled by 2^35; exact quotient for any 32-bit value
  localparam logic [MagW-1:0] RECIP10 = 32'hCCCC_CCCD;
  localparam int unsigned RecipShift  = 35;

  typedef logic [MagW-1:0] mag_t;

  // Powers of ten that decide the digit count
  typedef logic [MagW-1:0] pow_tab_t [9];
  localparam pow_tab_t POW10 = '{
    32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000,
    32'd10000000, 32'd100000000, 32'd1000000000
  };

  // Number of digits minus one: independent compares against the table
  function automatic logic [DigitW-1:0] digit_extra(input mag_t mag);
    logic [DigitW-1:0] cnt;
    cnt = '0;
    for (int k = 0; k < 9; k++) begin
      if (mag >= POW10[k]) begin
        cnt = cnt + 4'd1;
      end
    end
    return cnt;
  endfunction

endpackage

`default_nettype wire

@@ rtl/sd2a_div10.sv @@
// Shared divide-by-ten unit: quotient by reciprocal multiply, remainder by
// shift-add and subtract. Depends on sd2a_pkg.
`default_nettype none

module sd2a_div10 (
  input  wire  sd2a_pkg::mag_t                  dividend,
  output logic [sd2a_pkg::QuotW-1:0]            quotient,
  output logic [sd2a_pkg::DigitW-1:0]           remainder
);

  logic [2*sd2a_pkg::MagW-1:0] prod;
  logic [sd2a_pkg::MagW-1:0]   q_ext;
  logic [sd2a_pkg::MagW-1:0]   q_times10;
  logic [sd2a_pkg::MagW-1:0]   diff;

  // q = floor(x * RECIP10 / 2^35)
  assign prod     = 64'(dividend) * 64'(sd2a_pkg::RECIP10);
  assign quotient = prod[2*sd2a_pkg::MagW-1:sd2a_pkg::RecipShift];

  // remainder = x - 10*q, always below ten
  assign q_ext     = {3'b000, quotient};
  assign q_times10 = (q_ext << 3) + (q_ext << 1);
  assign diff      = dividend - q_times10;
  assign remainder = diff[sd2a_pkg::DigitW-1:0];

endmodule

`default_nettype wire

@@ rtl/signed_decimal_to_ascii_core.sv @@
// Top level: sequencer that turns a signed 32-bit value into ASCII digits.
// Depends on sd2a_pkg, sd2a_div10 and signed_decimal_to_ascii_core_assert.svh.
//
//   channel  | handshake         | payload
//   ---------+-------------------+--------------------------------------
//   input    | start / busy      | in_value (signed 32)
//   result   | out_valid strobe  | out_char_code, out_column, out_last
//
// Each item runs through the accept step, the sizing step and one digit step per
// digit before the next accept; busy is high in all but the accept step.
// The divide-by-ten unit yields one digit per cycle.
// The sign character is emitted during the sizing step, so it costs nothing.
// Results are registered and appear in the cycle after their step; the last one shows as busy drops.
// rst_n is synchronous; the receiver cannot stall, so nothing waits on it.
`default_nettype none

`include "signed_decimal_to_ascii_core_assert.svh"

module signed_decimal_to_ascii_core (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  output logic                              busy,
  input  wire  signed [31:0]                in_value,
  output logic                              out_valid,
  output logic [sd2a_pkg::CodeW-1:0]        out_char_code,
  output logic [sd2a_pkg::ColW-1:0]         out_column,
  output logic                              out_last
);

  typedef enum logic [1:0] {S_IDLE, S_SIZE, S_DIGIT} state_t;

  state_t                        state_r, state_nxt;
  logic                          neg_r, neg_nxt;
  sd2a_pkg::mag_t                mag_r, mag_nxt;
  logic [sd2a_pkg::ColW-1:0]     col_r, col_nxt;
  logic [sd2a_pkg::DigitW-1:0]   rem_r, rem_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [sd2a_pkg::CodeW-1:0]    out_code_r, out_code_nxt;
  logic [sd2a_pkg::ColW-1:0]     out_col_r, out_col_nxt;
  logic                          out_last_r, out_last_nxt;

  logic [sd2a_pkg::QuotW-1:0]    quot;
  logic [sd2a_pkg::DigitW-1:0]   digit;
  logic [sd2a_pkg::DigitW-1:0]   extra;
  logic [31:0]                   raw;

  // Shared divide unit works on the running magnitude
  sd2a_div10 u_div10 (
    .dividend  (mag_r),
    .quotient  (quot),
    .remainder (digit)
  );

  assign raw   = in_value;
  assign extra = sd2a_pkg::digit_extra(mag_r);

  // Sequencer next-state and output logic
  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    col_nxt       = col_r;
    rem_nxt       = rem_r;
    out_valid_nxt = 1'b0;
    out_code_nxt  = out_code_r;
    out_col_nxt   = out_col_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          neg_nxt   = raw[31];
          // unsigned magnitude; the most negative value stays 2^31
          mag_nxt   = raw[31] ? (32'd0 - raw) : raw;
          state_nxt = S_SIZE;
        end
      end
      S_SIZE: begin
        rem_nxt   = extra;
        col_nxt   = {3'b000, neg_r} + extra;
        state_nxt = S_DIGIT;
        if (neg_r) begin
          out_valid_nxt = 1'b1;
          out_code_nxt  = sd2a_pkg::ASCII_MINUS;
          out_col_nxt   = '0;
          out_last_nxt  = 1'b0;
        end
      end
      S_DIGIT: begin
        out_valid_nxt = 1'b1;
        out_code_nxt  = sd2a_pkg::ASCII_ZERO + {3'b000, digit};
        out_col_nxt   = col_r;
        out_last_nxt  = (rem_r == '0);
        mag_nxt       = {3'b000, quot};
        col_nxt       = col_r - 4'd1;
        rem_nxt       = rem_r - 4'd1;
        if (rem_r == '0) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    col_r      <= col_nxt;
    rem_r      <= rem_nxt;
    out_code_r <= out_code_nxt;
    out_col_r  <= out_col_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_char_code = out_code_r;
  assign out_column    = out_col_r;
  assign out_last      = out_last_r;

  // Checks
  `SD2A_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `SD2A_ASSERT_NEXT(a_stream_gapless, out_valid && !out_last, out_valid)
  `SD2A_ASSERT_NEXT(a_last_digit, state_r == S_DIGIT && rem_r == '0, out_valid && out_last)
  `SD2A_ASSERT_NOW(a_sign_place, out_valid && out_char_code == sd2a_pkg::ASCII_MINUS, out_column == '0 && !out_last)

endmodule

`default_nettype wire

@@ test/decimal_text_checker.sv @@
// Checker for signed_decimal_to_ascii_core: predicts the decimal ASCII text of
// each accepted value and compares every result transfer against it.
// Depends on sd2a_pkg for the result field widths and the ASCII codes.
`default_nettype none

module decimal_text_checker (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire                          busy,
  input  wire [31:0]                   in_value,
  input  wire                          out_valid,
  input  wire [sd2a_pkg::CodeW-1:0]    out_char_code,
  input  wire [sd2a_pkg::ColW-1:0]     out_column,
  input  wire                          out_last,
  output int unsigned                  mismatch_count,
  output int unsigned                  chars_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [sd2a_pkg::CodeW-1:0] code;
    logic [sd2a_pkg::ColW-1:0]  col;
    logic                       last;
  } ascii_char_t;

  localparam int unsigned ReportLimit = 10;

  ascii_char_t expected_chars[$];
  int unsigned errors = 0;

  // Queue the characters of one value: sign first, then digits right to left
  function automatic void push_decimal_text(input logic [31:0] value);
    logic        negative;
    logic [31:0] mag;
    logic [31:0] probe;
    logic [31:0] digit;
    logic [3:0]  extra;
    logic [3:0]  first_col;
    ascii_char_t ch;
    negative  = value[31];
    mag       = negative ? (32'd0 - value) : value;  // unsigned, so -2^31 works
    probe     = mag;
    extra     = '0;
    first_col = negative ? 4'd1 : 4'd0;
    while (probe >= 32'd10) begin
      probe = probe / 32'd10;
      extra = extra + 4'd1;
    end
    if (negative) begin
      ch.code = sd2a_pkg::ASCII_MINUS;
      ch.col  = 4'd0;
      ch.last = 1'b0;
      expected_chars.push_back(ch);
    end
    for (int i = 0; i <= int'(extra); i++) begin
      digit   = mag % 32'd10;
      ch.code = sd2a_pkg::ASCII_ZERO + digit[sd2a_pkg::CodeW-1:0];
      ch.col  = first_col + extra - 4'(i);
      ch.last = (i == int'(extra));
      expected_chars.push_back(ch);
      mag = mag / 32'd10;
    end
  endfunction

  // Accepted values feed the prediction; result transfers pop and compare
  always @(posedge clk) begin : watch
    ascii_char_t want;
    if (rst_n) begin
      if (start && !busy) begin
        push_decimal_text(in_value);
      end
      if (out_valid) begin
        if (expected_chars.size() == 0) begin
          errors++;
          if (errors <= ReportLimit) begin
            $display("[%0t] unexpected char: code=%h col=%0d last=%b",
                     $realtime, out_char_code, out_column, out_last);
          end
        end else begin
          want = expected_chars.pop_front();
          if (out_char_code !== want.code || out_column !== want.col ||
              out_last !== want.last) begin
            errors++;
            if (errors <= ReportLimit) begin
              $display({"[%0t] char mismatch: exp code=%h col=%0d last=%b,",
                        " got code=%h col=%0d last=%b"},
                       $realtime, want.code, want.col, want.last,
                       out_char_code, out_column, out_last);
            end
          end
        end
      end
    end
    mismatch_count <= errors;
    chars_pending  <= expected_chars.size();
  end

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Testbench top for signed_decimal_to_ascii_core: drives values through the
// start/busy handshake and reports the verdict of decimal_text_checker.
// Depends on sd2a_pkg, the core RTL and test/decimal_text_checker.sv.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned ItemsPerPass = 104;
  localparam int unsigned DrainCycles  = 20;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic [31:0]                 in_value = '0;
  logic                        busy;
  logic                        out_valid;
  logic [sd2a_pkg::CodeW-1:0]  out_char_code;
  logic [sd2a_pkg::ColW-1:0]   out_column;
  logic                        out_last;
  int unsigned                 mismatch_count;
  int unsigned                 chars_pending;
  int unsigned                 cycle_count = 0;
  int unsigned                 idle_pct = 0;

  // Extremes, digit-count boundaries and the sign cases
  logic [31:0] directed_vals [20] = '{
    32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
    32'd999999999, -32'sd999999999, -32'sd1000000000, 32'd7, -32'sd7,
    32'd123456789, -32'sd123456789, -32'sd9
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  signed_decimal_to_ascii_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_column    (out_column),
    .out_last      (out_last)
  );

  decimal_text_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_char_code  (out_char_code),
    .out_column     (out_column),
    .out_last       (out_last),
    .mismatch_count (mismatch_count),
    .chars_pending  (chars_pending)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Mostly a random digit count with a random sign, sometimes raw 32-bit noise
  function automatic logic [31:0] random_value();
    int unsigned ndig;
    logic        neg;
    longint      lo;
    longint      hi;
    logic [31:0] mag;
    if ($urandom_range(4) == 0) begin
      return $urandom();
    end
    ndig = $urandom_range(10, 1);
    neg  = 1'($urandom_range(1));
    lo   = 1;
    repeat (ndig - 1) lo = lo * 10;
    hi = lo * 10 - 1;
    if (ndig == 1) begin
      lo = 0;
    end
    if (hi > 64'd2147483647 + neg) begin
      hi = 64'd2147483647 + neg;
    end
    mag = 32'(lo) + $urandom_range(32'(hi - lo));
    return neg ? (32'd0 - mag) : mag;
  endfunction

  // One input transfer, preceded by random idle cycles
  task automatic send_value(input logic [31:0] value);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    start    <= 1'b1;
    in_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Three passes: light sender idling, heavy idling, back to back
    for (int pass = 0; pass < 3; pass++) begin
      idle_pct = (pass == 0) ? 12 : (pass == 1) ? 73 : 0;
      if (pass == 0) begin
        foreach (directed_vals[i]) send_value(directed_vals[i]);
      end
      repeat (ItemsPerPass) send_value(random_value());
    end
    start <= 1'b0;

    // Drain the remaining characters
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0 && chars_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
